@@ rtl/bbr_pkg.sv @@
// Package for the 3x3 RGB box blur: widths, register indexes, shared types
// and the reciprocal table used by the averaging pipeline. No dependencies.
`default_nettype none

package bbr_pkg;

  localparam int CH_W          = 8;
  localparam int PIX_W         = 3 * CH_W;
  localparam int LM_W          = 2 * PIX_W;
  localparam int CFG_W         = 14;
  localparam int CFG_IDX_W     = 2;
  localparam int WREG_W        = 11;
  localparam int HEIGHT_W      = 14;
  localparam int ROW_W         = HEIGHT_W + 1;
  localparam int DEF_MAX_WIDTH = 1024;
  localparam int RESET_WIDTH   = 640;
  localparam int RESET_HEIGHT  = 480;
  localparam int OFIFO_DEPTH   = 4;
  localparam int CNT_W         = 4;
  localparam int RECIP_SHIFT   = 24;
  localparam int RECIP_W       = 24;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  // Rounded-up reciprocals of twice the neighbor count, scaled by 2**RECIP_SHIFT.
  localparam logic [RECIP_W-1:0] RECIP_C1 = RECIP_W'((2**RECIP_SHIFT + 1) / 2);
  localparam logic [RECIP_W-1:0] RECIP_C2 = RECIP_W'((2**RECIP_SHIFT + 3) / 4);
  localparam logic [RECIP_W-1:0] RECIP_C3 = RECIP_W'((2**RECIP_SHIFT + 5) / 6);
  localparam logic [RECIP_W-1:0] RECIP_C4 = RECIP_W'((2**RECIP_SHIFT + 7) / 8);
  localparam logic [RECIP_W-1:0] RECIP_C6 = RECIP_W'((2**RECIP_SHIFT + 11) / 12);
  localparam logic [RECIP_W-1:0] RECIP_C9 = RECIP_W'((2**RECIP_SHIFT + 17) / 18);

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pix_t;

  typedef struct packed {
    logic top_ok;
    logic bot_ok;
    logic left_ok;
    logic right_ok;
    logic eof;
    logic last;
  } job_ctl_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            eof;
    logic            last;
  } result_t;

  function automatic logic [RECIP_W-1:0] bbr_recip(input logic [CNT_W-1:0] cnt);
    logic [RECIP_W-1:0] m;
    case (cnt)
      CNT_W'(2): m = RECIP_C2;
      CNT_W'(3): m = RECIP_C3;
      CNT_W'(4): m = RECIP_C4;
      CNT_W'(6): m = RECIP_C6;
      CNT_W'(9): m = RECIP_C9;
      default:   m = RECIP_C1;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

@@ rtl/bbr_in_if.sv @@
// Input channel of the box blur: valid/ready handshake with a pixel or drain item.
// Depends on bbr_pkg for the channel width.
`default_nettype none

interface bbr_in_if import bbr_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            operation;
  logic [CH_W-1:0] in_red;
  logic [CH_W-1:0] in_green;
  logic [CH_W-1:0] in_blue;

  modport source (output valid, operation, in_red, in_green, in_blue, input ready);
  modport sink   (input valid, operation, in_red, in_green, in_blue, output ready);
endinterface

`default_nettype wire

@@ rtl/bbr_out_if.sv @@
// Result channel of the box blur: valid/ready handshake with one blurred pixel.
// Depends on bbr_pkg for the channel width.
`default_nettype none

interface bbr_out_if import bbr_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] out_red;
  logic [CH_W-1:0] out_green;
  logic [CH_W-1:0] out_blue;
  logic            end_of_frame;
  logic            last_of_run;

  modport source (output valid, out_red, out_green, out_blue, end_of_frame, last_of_run,
                  input ready);
  modport sink   (input valid, out_red, out_green, out_blue, end_of_frame, last_of_run,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/bbr_line_mem.sv @@
// Line memory holding the two previous rows per column, one read and one write port,
// registered read data. Depends on bbr_pkg for the entry width.
`default_nettype none

module bbr_line_mem import bbr_pkg::*; #(
  parameter int DEPTH = DEF_MAX_WIDTH
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [LM_W-1:0]          rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [LM_W-1:0]          wr_data
);

  logic [LM_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/bbr_mean.sv @@
// Two-stage averaging pipeline: masked 3x3 sums, then rounded division by the
// neighbor count through a reciprocal multiply. Depends on bbr_pkg.
`default_nettype none

module bbr_mean import bbr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_valid,
  input  job_ctl_t           job_ctl,
  input  pix_t [2:0][2:0]    win,
  output logic               res_valid,
  output result_t            res,
  output logic [1:0]         pipe_used
);

  localparam int SUM_W  = CH_W + 4;
  localparam int NUM_W  = SUM_W + 1;
  localparam int PROD_W = NUM_W + RECIP_W;

  logic [2:0]                   row_ok;
  logic [2:0]                   col_ok;
  logic [1:0]                   rows;
  logic [1:0]                   cols;
  logic [CNT_W-1:0]             cnt;
  logic [2:0][SUM_W-1:0]        sum;
  logic [2:0][NUM_W-1:0]        num;
  logic [2:0][PROD_W-1:0]       prod;

  logic                         s1_valid_r;
  logic [2:0][NUM_W-1:0]        s1_num_r;
  logic [RECIP_W-1:0]           s1_recip_r;
  logic                         s1_eof_r;
  logic                         s1_last_r;
  logic                         s2_valid_r;
  result_t                      s2_res_r;

  assign row_ok = {job_ctl.bot_ok, 1'b1, job_ctl.top_ok};
  assign col_ok = {job_ctl.right_ok, 1'b1, job_ctl.left_ok};
  assign rows   = 2'd1 + {1'b0, job_ctl.top_ok} + {1'b0, job_ctl.bot_ok};
  assign cols   = 2'd1 + {1'b0, job_ctl.left_ok} + {1'b0, job_ctl.right_ok};
  assign cnt    = {2'b00, rows} * {2'b00, cols};

  always_comb begin
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (row_ok[i] && col_ok[j]) begin
          sum[0] = sum[0] + SUM_W'(win[i][j].red);
          sum[1] = sum[1] + SUM_W'(win[i][j].green);
          sum[2] = sum[2] + SUM_W'(win[i][j].blue);
        end
      end
    end
    for (int k = 0; k < 3; k++) begin
      num[k] = {sum[k], 1'b0} + NUM_W'(cnt);
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod[k] = s1_num_r[k] * s1_recip_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= job_valid;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_num_r       <= num;
    s1_recip_r     <= bbr_recip(cnt);
    s1_eof_r       <= job_ctl.eof;
    s1_last_r      <= job_ctl.last;
    s2_res_r.red   <= prod[0][RECIP_SHIFT +: CH_W];
    s2_res_r.green <= prod[1][RECIP_SHIFT +: CH_W];
    s2_res_r.blue  <= prod[2][RECIP_SHIFT +: CH_W];
    s2_res_r.eof   <= s1_eof_r;
    s2_res_r.last  <= s1_last_r;
  end

  assign res_valid = s2_valid_r;
  assign res       = s2_res_r;
  assign pipe_used = {1'b0, s1_valid_r} + {1'b0, s2_valid_r};

endmodule

`default_nettype wire

@@ rtl/bbr_out_fifo.sv @@
// Small result queue between the averaging pipeline and the result channel.
// Depends on bbr_pkg and bbr_out_if.
`default_nettype none

module bbr_out_fifo import bbr_pkg::*; #(
  parameter int DEPTH = OFIFO_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  result_t                    push_data,
  output logic [$clog2(DEPTH+1)-1:0] count,
  bbr_out_if.source                  out_px
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FCW = $clog2(DEPTH + 1);

  result_t         ent [DEPTH];
  logic [AW-1:0]   wr_ptr_r;
  logic [AW-1:0]   rd_ptr_r;
  logic [FCW-1:0]  count_r;
  logic            pop;
  result_t         head;

  assign pop  = out_px.valid && out_px.ready;
  assign head = ent[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      count_r <= count_r + FCW'(push) - FCW'(pop);
    end
  end

  assign count               = count_r;
  assign out_px.valid        = (count_r != '0);
  assign out_px.out_red      = head.red;
  assign out_px.out_green    = head.green;
  assign out_px.out_blue     = head.blue;
  assign out_px.end_of_frame = head.eof;
  assign out_px.last_of_run  = head.last;

endmodule

`default_nettype wire

@@ rtl/box_blur_3x3_rgb_unit.sv @@
// Top level of the 3x3 RGB box blur: position sequencer, 3x3 window and config
// registers. Depends on bbr_pkg, bbr_in_if, bbr_out_if, bbr_line_mem, bbr_mean, bbr_out_fifo.
//
// Pixels enter on in_px in raster order; each result on out_px is one pixel replaced
// by the rounded mean of its in-frame 3x3 neighbors, trailing the input by one row and
// one pixel. After the last pixel, drain items (operation = 1) flush the pending
// results, up to two per drain item; end_of_frame marks the final pixel of the frame.
// A pixel item is taken as the line memory read, the read-modify-write of
// that entry with the window shift, and the hand-off to the averaging pipeline.
// A drain item flushes one position after another, at most four positions.
// A result passes the window update, both averaging stages and the queue before it is shown.
// The config port writes image_width and image_height and restarts the frame.
// Reset sets a 640 x 480 frame, empties the queue and starts at the first pixel; the
// line memory is not cleared, since data read before an entry was written is masked out.
// When the receiver stalls, results wait in a four-entry queue; once the queue and the
// pipeline are full the sequencer holds and in_px.ready stays low.
`default_nettype none

module box_blur_3x3_rgb_unit import bbr_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int FIFO_DEPTH = OFIFO_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  bbr_in_if.sink               in_px,
  bbr_out_if.source            out_px
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WB  = $clog2(MAX_WIDTH + 1);
  localparam int EW  = (WB > WREG_W) ? WB : WREG_W;
  localparam int FCW = $clog2(FIFO_DEPTH + 1);
  localparam logic [2:0] DRAIN_GUARD = 3'd4;
  localparam logic [1:0] DRAIN_MAX   = 2'd2;

  typedef enum logic [1:0] {S_IDLE, S_ADV, S_EMIT} state_t;

  function automatic logic [EW-1:0] eff_w(input logic [WREG_W-1:0] v);
    logic [EW-1:0] x;
    x = EW'(v);
    if (x == '0) begin
      x = EW'(1);
    end else if (x > EW'(MAX_WIDTH)) begin
      x = EW'(MAX_WIDTH);
    end
    return x;
  endfunction

  function automatic logic [HEIGHT_W-1:0] eff_h(input logic [HEIGHT_W-1:0] v);
    return (v == '0) ? HEIGHT_W'(1) : v;
  endfunction

  state_t                state_r, state_nxt;
  logic [CW-1:0]         col_r, col_nxt;
  logic [ROW_W-1:0]      row_r, row_nxt;
  logic                  drain_r, drain_nxt;
  logic [1:0]            res_cnt_r, res_cnt_nxt;
  logic [2:0]            guard_r, guard_nxt;
  logic                  has_r, has_nxt;
  job_ctl_t              ctl_r, ctl_nxt;
  logic [EW-1:0]         width_r, width_nxt;
  logic [HEIGHT_W-1:0]   height_r, height_nxt;
  pix_t                  pix_r, pix_nxt;
  pix_t [2:0][2:0]       win_r, win_nxt;

  logic                  in_fire;
  logic                  row_done;
  logic                  col_zero;
  logic                  col_last;
  logic [CW-1:0]         col_step;
  logic [ROW_W-1:0]      row_step;
  logic [ROW_W-1:0]      orow;
  logic [ROW_W-1:0]      h_m1;
  logic                  adv_has;
  job_ctl_t              adv_ctl;
  logic                  credit_ok;
  logic                  emit_go;
  logic [1:0]            res_cnt_new;

  logic                  mem_rd_en;
  logic [CW-1:0]         mem_rd_addr;
  logic [LM_W-1:0]       mem_rd_data;
  logic                  mem_wr_en;
  pix_t                  rd_top;
  pix_t                  rd_mid;

  logic                  job_valid;
  job_ctl_t              job_ctl;
  logic                  res_valid;
  result_t               res;
  logic [1:0]            pipe_used;
  logic [FCW-1:0]        fifo_count;

  assign in_px.ready = (state_r == S_IDLE);
  assign in_fire     = in_px.valid && in_px.ready;
  assign row_done    = (row_r >= {1'b0, height_r});

  assign rd_top = mem_rd_data[LM_W-1:PIX_W];
  assign rd_mid = mem_rd_data[PIX_W-1:0];

  assign col_zero = (col_r == '0);
  assign col_last = (EW'(col_r) == width_r - EW'(1));
  assign col_step = col_last ? '0 : col_r + CW'(1);
  assign row_step = col_last ? row_r + ROW_W'(1) : row_r;
  assign h_m1     = {1'b0, height_r} - ROW_W'(1);

  // The first column of a row finishes the last pixel of the row two above.
  assign orow             = col_zero ? row_r - ROW_W'(2) : row_r - ROW_W'(1);
  assign adv_has          = col_zero ? (row_r >= ROW_W'(2)) : (row_r >= ROW_W'(1));
  assign adv_ctl.top_ok   = (orow != '0);
  assign adv_ctl.bot_ok   = (orow < h_m1);
  assign adv_ctl.left_ok  = col_zero ? (width_r != EW'(1)) : (col_r != CW'(1));
  assign adv_ctl.right_ok = !col_zero;
  assign adv_ctl.eof      = col_zero && (orow == h_m1);
  assign adv_ctl.last     = 1'b0;

  assign credit_ok = ((FCW + 1)'(fifo_count) + (FCW + 1)'(pipe_used)) < (FCW + 1)'(FIFO_DEPTH);
  assign emit_go   = !has_r || credit_ok;
  assign res_cnt_new = res_cnt_r + {1'b0, has_r};

  always_comb begin
    state_nxt   = state_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    drain_nxt   = drain_r;
    res_cnt_nxt = res_cnt_r;
    guard_nxt   = guard_r;
    has_nxt     = has_r;
    ctl_nxt     = ctl_r;
    width_nxt   = width_r;
    height_nxt  = height_r;
    pix_nxt     = pix_r;
    win_nxt     = win_r;
    mem_rd_en   = 1'b0;
    mem_rd_addr = col_r;
    mem_wr_en   = 1'b0;
    job_valid   = 1'b0;
    job_ctl     = ctl_r;
    job_ctl.last = !drain_r || ctl_r.eof || (res_cnt_r == 2'd1);

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (!in_px.operation && !row_done) begin
            pix_nxt   = {in_px.in_red, in_px.in_green, in_px.in_blue};
            drain_nxt = 1'b0;
            mem_rd_en = 1'b1;
            state_nxt = S_ADV;
          end else if (in_px.operation && row_done) begin
            pix_nxt     = '0;
            drain_nxt   = 1'b1;
            res_cnt_nxt = '0;
            guard_nxt   = '0;
            mem_rd_en   = 1'b1;
            state_nxt   = S_ADV;
          end
        end
      end
      S_ADV: begin
        mem_wr_en = 1'b1;
        for (int i = 0; i < 3; i++) begin
          win_nxt[i][0] = win_r[i][1];
          win_nxt[i][1] = win_r[i][2];
        end
        win_nxt[0][2] = rd_top;
        win_nxt[1][2] = rd_mid;
        win_nxt[2][2] = pix_r;
        has_nxt   = adv_has;
        ctl_nxt   = adv_ctl;
        guard_nxt = guard_r + 3'd1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (emit_go) begin
          job_valid   = has_r;
          res_cnt_nxt = res_cnt_new;
          if (has_r && ctl_r.eof) begin
            col_nxt = '0;
            row_nxt = '0;
          end else begin
            col_nxt = col_step;
            row_nxt = row_step;
          end
          if (drain_r && !(has_r && ctl_r.eof) && (res_cnt_new < DRAIN_MAX) &&
              (guard_r < DRAIN_GUARD)) begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = col_step;
            state_nxt   = S_ADV;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH: begin
          width_nxt = eff_w(cfg_wdata[WREG_W-1:0]);
          col_nxt   = '0;
          row_nxt   = '0;
        end
        REG_IMAGE_HEIGHT: begin
          height_nxt = eff_h(cfg_wdata[HEIGHT_W-1:0]);
          col_nxt    = '0;
          row_nxt    = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      col_r     <= '0;
      row_r     <= '0;
      drain_r   <= 1'b0;
      res_cnt_r <= '0;
      guard_r   <= '0;
      has_r     <= 1'b0;
      ctl_r     <= '0;
      width_r   <= eff_w(WREG_W'(RESET_WIDTH));
      height_r  <= HEIGHT_W'(RESET_HEIGHT);
    end else begin
      state_r   <= state_nxt;
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      drain_r   <= drain_nxt;
      res_cnt_r <= res_cnt_nxt;
      guard_r   <= guard_nxt;
      has_r     <= has_nxt;
      ctl_r     <= ctl_nxt;
      width_r   <= width_nxt;
      height_r  <= height_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pix_r <= pix_nxt;
    win_r <= win_nxt;
  end

  bbr_line_mem #(
    .DEPTH (MAX_WIDTH)
  ) u_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (col_r),
    .wr_data ({rd_mid, pix_r})
  );

  bbr_mean u_mean (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job_ctl   (job_ctl),
    .win       (win_r),
    .res_valid (res_valid),
    .res       (res),
    .pipe_used (pipe_used)
  );

  bbr_out_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .count     (fifo_count),
    .out_px    (out_px)
  );

  // The sequencer never reads and writes the line memory in the same cycle.
  assert property (@(posedge clk) disable iff (!rst_n) !(mem_rd_en && mem_wr_en))
    else $error("line memory read and write overlap");

  // Every memory read is followed by the update step that consumes its data.
  assert property (@(posedge clk) disable iff (!rst_n) mem_rd_en |=> (state_r == S_ADV))
    else $error("memory read data not consumed");

  // The credit check keeps the result queue from overflowing.
  assert property (@(posedge clk) disable iff (!rst_n)
                   res_valid |-> (fifo_count != FCW'(FIFO_DEPTH)))
    else $error("result queue overflow");

  // The final pixel of a frame restarts the positions and ends the drain.
  assert property (@(posedge clk) disable iff (!rst_n)
                   (job_valid && job_ctl.eof) |=>
                   ((row_r == '0) && (col_r == '0) && (state_r == S_IDLE)))
    else $error("frame not restarted after its final pixel");

endmodule

`default_nettype wire

@@ bench/tb_box_blur_3x3_rgb_unit.sv @@
// Self-checking testbench for box_blur_3x3_rgb_unit: directed rows, then randomized frames.
// Depends on bbr_pkg, bbr_in_if, bbr_out_if and the RTL of the blur unit.
// Results are predicted by a behavioral blur in this file or given in directed rows, and checked in order.
module tb_box_blur_3x3_rgb_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import bbr_pkg::*;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(3);
  localparam int SETTLE_CYCLES = 32;
  localparam int LONG_HOLD = 300;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int RANDOM_ITEMS = 720;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     data;
    logic                 op;
    pix_t                 pix;
    logic                 use_model;
    logic [1:0]           n_typed;
    result_t              typed;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  bbr_in_if  in_bus ();
  bbr_out_if out_bus ();

  box_blur_3x3_rgb_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_px     (in_bus),
    .out_px    (out_bus)
  );

  always #5 clk = ~clk;

  logic [WREG_W-1:0]   width_reg;
  logic [HEIGHT_W-1:0] height_reg;
  pix_t                upper_line [DEF_MAX_WIDTH];
  pix_t                middle_line [DEF_MAX_WIDTH];
  pix_t                nbhd [3][3];
  int                  px_col;
  int                  px_row;
  bit                  frame_done;
  bit                  step_took;
  result_t             blur_out[$];
  result_t             blurred_q[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_trigger = 0;
  int fail_count = 0;
  int cycle_count = 0;
  int items_taken = 0;
  int results_checked = 0;
  int frames_set = 0;

  function automatic int eff_width();
    int w;
    w = width_reg;
    if (w == 0) w = 1;
    if (w > DEF_MAX_WIDTH) w = DEF_MAX_WIDTH;
    return w;
  endfunction

  function automatic int eff_height();
    int h;
    h = height_reg;
    if (h == 0) h = 1;
    return h;
  endfunction

  function automatic void restart_frame();
    px_col = 0;
    px_row = 0;
    frame_done = 1'b0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) nbhd[i][j] = '0;
    end
  endfunction

  function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_W-1:0] data);
    if (idx == REG_IMAGE_WIDTH) begin
      width_reg = data[WREG_W-1:0];
      restart_frame();
    end else if (idx == REG_IMAGE_HEIGHT) begin
      height_reg = data[HEIGHT_W-1:0];
      restart_frame();
    end
  endfunction

  function automatic result_t blur_at(input int cidx, input int orow, input int ocol,
                                      input int w, input int h);
    int sum_r;
    int sum_g;
    int sum_b;
    int cnt;
    bit counted;
    result_t res;
    sum_r = 0;
    sum_g = 0;
    sum_b = 0;
    cnt = 0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        counted = !(i == 0 && orow == 0) && !(i == 2 && orow + 1 >= h) &&
                  (j + 1 >= cidx) && (j <= cidx + 1) &&
                  !(j + 1 == cidx && ocol == 0) && !(j == cidx + 1 && ocol + 1 >= w);
        if (counted) begin
          sum_r += nbhd[i][j].red;
          sum_g += nbhd[i][j].green;
          sum_b += nbhd[i][j].blue;
          cnt++;
        end
      end
    end
    if (cnt == 0) cnt = 1;
    res.red   = CH_W'((2 * sum_r + cnt) / (2 * cnt));
    res.green = CH_W'((2 * sum_g + cnt) / (2 * cnt));
    res.blue  = CH_W'((2 * sum_b + cnt) / (2 * cnt));
    res.eof   = (orow == h - 1) && (ocol == w - 1);
    res.last  = 1'b0;
    if (res.eof) frame_done = 1'b1;
    return res;
  endfunction

  function automatic void blur_advance(input pix_t pix);
    int w;
    int h;
    int r;
    int c;
    pix_t top;
    pix_t mid;
    w = eff_width();
    h = eff_height();
    r = px_row;
    c = px_col;
    if (c >= w) c = 0;
    if (c == 0 && r >= 2) blur_out.push_back(blur_at(2, r - 2, w - 1, w, h));
    top = upper_line[c];
    mid = middle_line[c];
    upper_line[c] = mid;
    middle_line[c] = pix;
    for (int i = 0; i < 3; i++) begin
      nbhd[i][0] = nbhd[i][1];
      nbhd[i][1] = nbhd[i][2];
    end
    nbhd[0][2] = top;
    nbhd[1][2] = mid;
    nbhd[2][2] = pix;
    if (c >= 1 && r >= 1) blur_out.push_back(blur_at(1, r - 1, c - 1, w, h));
    c++;
    if (c >= w) begin
      c = 0;
      r++;
    end
    px_col = c;
    px_row = r;
    if (frame_done) restart_frame();
  endfunction

  function automatic void blur_step(input logic op, input pix_t pix);
    int h;
    int guard;
    bit at_end;
    result_t tail;
    h = eff_height();
    blur_out.delete();
    step_took = 1'b0;
    if (op == OP_PIXEL) begin
      if (px_row < h) begin
        blur_advance(pix);
        step_took = 1'b1;
      end
    end else if (px_row >= h) begin
      step_took = 1'b1;
      guard = 0;
      at_end = 1'b0;
      while (blur_out.size() < 2 && guard < 4 && !at_end) begin
        blur_advance('0);
        guard++;
        if (blur_out.size() > 0) begin
          tail = blur_out[blur_out.size() - 1];
          at_end = tail.eof;
        end
      end
    end
    if (blur_out.size() > 0) begin
      tail = blur_out.pop_back();
      tail.last = 1'b1;
      blur_out.push_back(tail);
    end
  endfunction

  function automatic pix_t rand_pixel();
    logic [PIX_W-1:0] bits;
    pix_t p;
    bits = PIX_W'($urandom);
    p = bits;
    if ($urandom_range(9) == 0) begin
      p.red   = {CH_W{bits[0]}};
      p.green = {CH_W{bits[1]}};
      p.blue  = {CH_W{bits[2]}};
    end
    return p;
  endfunction

  function automatic stim_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_W-1:0] data);
    stim_row_t row;
    row = '0;
    row.kind = ROW_CFG;
    row.idx = idx;
    row.data = data;
    return row;
  endfunction

  function automatic stim_row_t item_row(input logic op, input logic [CH_W-1:0] r,
                                         input logic [CH_W-1:0] g, input logic [CH_W-1:0] b,
                                         input logic use_model, input int n_typed,
                                         input result_t typed);
    stim_row_t row;
    row = '0;
    row.kind = ROW_ITEM;
    row.op = op;
    row.pix.red = r;
    row.pix.green = g;
    row.pix.blue = b;
    row.use_model = use_model;
    row.n_typed = n_typed[1:0];
    row.typed = typed;
    return row;
  endfunction

  task automatic offer_item(input logic op, input pix_t pix, input logic use_model,
                            input int n_typed, input result_t typed);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.operation <= op;
    in_bus.in_red    <= pix.red;
    in_bus.in_green  <= pix.green;
    in_bus.in_blue   <= pix.blue;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    blur_step(op, pix);
    if (step_took) items_taken++;
    if (use_model) begin
      foreach (blur_out[k]) blurred_q.push_back(blur_out[k]);
    end else if (n_typed > 0) begin
      blurred_q.push_back(typed);
    end
  endtask

  task automatic go_idle();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (blurred_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    apply_register(idx, data);
  endtask

  task automatic configure(input logic [CFG_W-1:0] wdata, input logic [CFG_W-1:0] hdata);
    go_idle();
    write_register(REG_IMAGE_WIDTH, wdata);
    write_register(REG_IMAGE_HEIGHT, hdata);
    frames_set++;
  endtask

  // A negative pixel limit streams the whole frame and drains it to its end.
  task automatic stream_frame(input int max_pixels);
    int sent;
    int h;
    int extra;
    sent = 0;
    h = eff_height();
    while (px_row < h && (max_pixels < 0 || sent < max_pixels)) begin
      if ($urandom_range(99) < 3) offer_item(OP_DRAIN, rand_pixel(), 1'b1, 0, '0);
      if ((max_pixels > 0 && sent == 10) || $urandom_range(199) == 0) go_idle();
      offer_item(OP_PIXEL, rand_pixel(), 1'b1, 0, '0);
      sent++;
    end
    if (max_pixels < 0) begin
      extra = ($urandom_range(9) < 3) ? $urandom_range(1, 2) : 0;
      repeat (extra) offer_item(OP_PIXEL, rand_pixel(), 1'b1, 0, '0);
      while (px_row >= h) offer_item(OP_DRAIN, rand_pixel(), 1'b1, 0, '0);
    end
  endtask

  task automatic check_field(input string name, input logic [CH_W-1:0] want,
                             input logic [CH_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      if (blurred_q.size() == 0) begin
        $error("result transfer with no result expected");
        fail_count++;
      end else begin
        want = blurred_q.pop_front();
        check_field("out_red", want.red, out_bus.out_red);
        check_field("out_green", want.green, out_bus.out_green);
        check_field("out_blue", want.blue, out_bus.out_blue);
        check_field("end_of_frame", want.eof, out_bus.end_of_frame);
        check_field("last_of_run", want.last, out_bus.last_of_run);
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $error("timeout with %0d results still expected", blurred_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : drive_ready
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_trigger) begin
        hold_seen = hold_trigger;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin : main_flow
    stim_row_t directed_rows[$];
    stim_row_t row;
    int phase_start;
    int w_val;
    int h_val;
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= '0;
    cfg_wdata        <= '0;
    in_bus.valid     <= 1'b0;
    in_bus.operation <= OP_PIXEL;
    in_bus.in_red    <= '0;
    in_bus.in_green  <= '0;
    in_bus.in_blue   <= '0;
    width_reg  = WREG_W'(RESET_WIDTH);
    height_reg = HEIGHT_W'(RESET_HEIGHT);
    for (int k = 0; k < DEF_MAX_WIDTH; k++) begin
      upper_line[k] = '0;
      middle_line[k] = '0;
    end
    restart_frame();

    directed_rows.push_back(item_row(OP_DRAIN, 8'hAA, 8'h55, 8'hFF, 1'b0, 0, '0));
    directed_rows.push_back(item_row(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF, 1'b0, 0, '0));
    directed_rows.push_back(reg_row(REG_IMAGE_WIDTH, 14'd1));
    directed_rows.push_back(reg_row(REG_IMAGE_HEIGHT, 14'd1));
    directed_rows.push_back(item_row(OP_PIXEL, 8'd255, 8'd0, 8'd128, 1'b0, 0, '0));
    directed_rows.push_back(item_row(OP_PIXEL, 8'd1, 8'd2, 8'd3, 1'b0, 0, '0));
    directed_rows.push_back(item_row(OP_DRAIN, 8'd0, 8'd0, 8'd0, 1'b0, 1,
                                     result_t'{8'd255, 8'd0, 8'd128, 1'b1, 1'b1}));
    directed_rows.push_back(item_row(OP_DRAIN, 8'd0, 8'd0, 8'd0, 1'b0, 0, '0));
    directed_rows.push_back(reg_row(REG_IMAGE_WIDTH, 14'd0));
    directed_rows.push_back(reg_row(REG_IMAGE_HEIGHT, 14'd0));
    directed_rows.push_back(item_row(OP_PIXEL, 8'd0, 8'd255, 8'd1, 1'b0, 0, '0));
    directed_rows.push_back(item_row(OP_DRAIN, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1,
                                     result_t'{8'd0, 8'd255, 8'd1, 1'b1, 1'b1}));
    directed_rows.push_back(reg_row(REG_IMAGE_WIDTH, 14'd3));
    directed_rows.push_back(reg_row(REG_IMAGE_HEIGHT, 14'd3));
    directed_rows.push_back(item_row(OP_PIXEL, 8'd255, 8'd0, 8'd255, 1'b1, 0, '0));
    directed_rows.push_back(item_row(OP_PIXEL, 8'd0, 8'd255, 8'd0, 1'b1, 0, '0));
    directed_rows.push_back(item_row(OP_PIXEL, 8'd255, 8'd255, 8'd255, 1'b1, 0, '0));
    directed_rows.push_back(item_row(OP_PIXEL, 8'd0, 8'd0, 8'd0, 1'b1, 0, '0));
    directed_rows.push_back(reg_row(REG_UNUSED, 14'h3FFF));
    directed_rows.push_back(item_row(OP_PIXEL, 8'd128, 8'd127, 8'd1, 1'b1, 0, '0));
    directed_rows.push_back(item_row(OP_PIXEL, 8'd255, 8'd0, 8'd0, 1'b1, 0, '0));
    directed_rows.push_back(item_row(OP_DRAIN, 8'd9, 8'd9, 8'd9, 1'b0, 0, '0));
    directed_rows.push_back(item_row(OP_PIXEL, 8'd0, 8'd0, 8'd255, 1'b1, 0, '0));
    directed_rows.push_back(item_row(OP_PIXEL, 8'd1, 8'd1, 8'd1, 1'b1, 0, '0));
    directed_rows.push_back(item_row(OP_PIXEL, 8'd254, 8'd255, 8'd0, 1'b1, 0, '0));
    directed_rows.push_back(item_row(OP_DRAIN, 8'd0, 8'd0, 8'd0, 1'b1, 0, '0));
    directed_rows.push_back(item_row(OP_DRAIN, 8'd0, 8'd0, 8'd0, 1'b1, 0, '0));

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[k]) begin
      row = directed_rows[k];
      if (row.kind == ROW_CFG) begin
        go_idle();
        write_register(row.idx, row.data);
      end else begin
        offer_item(row.op, row.pix, row.use_model, row.n_typed, row.typed);
      end
    end

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          configure(14'h07FF, 14'd1);
          hold_trigger++;
          stream_frame(64);
        end
        1: begin
          send_idle_pct = 79;
          recv_stall_pct = 0;
          configure(14'd5, 14'h3FFF);
          stream_frame(40);
          configure(14'd0, 14'd3);
          stream_frame(-1);
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 79;
          configure({3'b101, 11'd6}, 14'd0);
          stream_frame(-1);
          configure(14'd7, 14'h2AAA);
          stream_frame(30);
        end
        default: begin
          send_idle_pct = 21;
          recv_stall_pct = 21;
          configure(14'd20, 14'd4);
          hold_trigger++;
          stream_frame(-1);
        end
      endcase
      phase_start = items_taken;
      while (items_taken - phase_start < RANDOM_ITEMS / 4) begin
        w_val = ($urandom_range(4) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        h_val = $urandom_range(1, 6);
        configure(CFG_W'(w_val), CFG_W'(h_val));
        stream_frame(-1);
      end
    end

    go_idle();
    $display("Summary: %0d frame settings, %0d items taken, %0d results checked,",
             frames_set, items_taken, results_checked);
    $display("  under free flow, sender gaps, receiver stalls and long back-pressure.");
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
